// ===== design/rsng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo RMS noise gate package
// Shared constants, register map, sequencer states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsng_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Gate gain is unsigned Q1.15; one is held exactly.
  localparam int          GAIN_W   = 16;
  localparam logic [15:0] GAIN_ONE = 16'h8000;

  // Fraction bits of sample * gain (Q1.15) * makeup (Q5.10).
  localparam int OUT_FRAC = 25;

  localparam int STEP_W   = 16;
  localparam int LEVEL_W  = 16;
  localparam int MAKEUP_W = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0]   ATTACK_RST    = 16'd14;
  localparam logic [STEP_W-1:0]   RELEASE_RST   = 16'd7;
  localparam logic [LEVEL_W-1:0]  THRESHOLD_RST = 16'd33;
  localparam logic [MAKEUP_W-1:0] MAKEUP_RST    = 15'd1024;
  localparam logic [GAIN_W-1:0]   MIN_GAIN_RST  = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK    = 3'd0,
    CFG_RELEASE   = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_MAKEUP    = 3'd3,
    CFG_MIN_GAIN  = 3'd4,
    CFG_SIDECHAIN = 3'd5,
    CFG_INVERTED  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [STEP_W-1:0]   attack_step;
    logic [STEP_W-1:0]   release_step;
    logic [LEVEL_W-1:0]  threshold_level;
    logic [MAKEUP_W-1:0] makeup_gain;
    logic [GAIN_W-1:0]   min_gate_gain;
    logic                sidechain_mode;
    logic                inverted_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_COMPARE,
    ST_GAIN,
    ST_MUL_GAIN,
    ST_MUL_MAKEUP,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic square;
    logic sum;
    logic compare;
    logic gain;
    logic mul_gain;
    logic mul_makeup;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } status_t;

endpackage

// ===== design/rsng_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo RMS noise gate channels
// Frame input, gated output and register write channels, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsng_in_if #(
  parameter int SAMPLE_WIDTH = rsng_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_sample;
  logic signed [SAMPLE_WIDTH-1:0] right_sample;
  logic signed [SAMPLE_WIDTH-1:0] side_sample;

  modport source (output valid, left_sample, right_sample, side_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, side_sample, output ready);
endinterface

interface rsng_out_if #(
  parameter int SAMPLE_WIDTH = rsng_pkg::SAMPLE_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [SAMPLE_WIDTH-1:0]   out_left;
  logic signed [SAMPLE_WIDTH-1:0]   out_right;
  logic [rsng_pkg::GAIN_W-1:0]      gate_gain;

  modport source (output valid, out_left, out_right, gate_gain, input ready);
  modport sink   (input valid, out_left, out_right, gate_gain, output ready);
endinterface

interface rsng_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rsng_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [rsng_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== design/rsng_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register file
// Holds the gate settings; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module rsng_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  rsng_cfg_if.sink       cfg_i,
  output rsng_pkg::cfg_t cfg_o
);

  rsng_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step     <= rsng_pkg::ATTACK_RST;
      cfg_q.release_step    <= rsng_pkg::RELEASE_RST;
      cfg_q.threshold_level <= rsng_pkg::THRESHOLD_RST;
      cfg_q.makeup_gain     <= rsng_pkg::MAKEUP_RST;
      cfg_q.min_gate_gain   <= rsng_pkg::MIN_GAIN_RST;
      cfg_q.sidechain_mode  <= 1'b0;
      cfg_q.inverted_mode   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (rsng_pkg::cfg_idx_e'(cfg_i.reg_index))
        rsng_pkg::CFG_ATTACK:    cfg_q.attack_step     <= cfg_i.wdata;
        rsng_pkg::CFG_RELEASE:   cfg_q.release_step    <= cfg_i.wdata;
        rsng_pkg::CFG_THRESHOLD: cfg_q.threshold_level <= cfg_i.wdata;
        rsng_pkg::CFG_MAKEUP:
          cfg_q.makeup_gain <= cfg_i.wdata[rsng_pkg::MAKEUP_W-1:0];
        rsng_pkg::CFG_MIN_GAIN:  cfg_q.min_gate_gain   <= cfg_i.wdata;
        rsng_pkg::CFG_SIDECHAIN: cfg_q.sidechain_mode  <= cfg_i.wdata[0];
        rsng_pkg::CFG_INVERTED:  cfg_q.inverted_mode   <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rsng_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample window
// Ring memory of the most recent samples with a read-first port that returns
// the sample being replaced.
// ----------------------------------------------------------------------------
module rsng_window #(
  parameter int WINDOW_DEPTH = rsng_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = rsng_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] old_o
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);

  logic [SAMPLE_WIDTH-1:0] mem_q [WINDOW_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_q;
  logic [PTR_W-1:0]        ptr_q;
  logic [PTR_W-1:0]        ptr_d;
  logic                    full_q;
  logic                    old_vld_q;

  // Slots are filled in ring order from slot one, so every slot has been
  // written once the pointer has wrapped back to slot zero.
  assign ptr_d = (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      full_q    <= 1'b0;
      old_vld_q <= 1'b0;
    end else if (push_i) begin
      ptr_q     <= ptr_d;
      old_vld_q <= full_q;
      if (ptr_d == '0) begin
        full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rd_q          <= mem_q[ptr_d];
      mem_q[ptr_d]  <= sample_i;
    end
  end

  assign old_o = old_vld_q ? $signed(rd_q) : '0;

endmodule

// ===== design/rsng_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate sequencer
// Steps one frame through square, sum, compare, gain ramp, two multiplier
// stages and rounding.
// ----------------------------------------------------------------------------
module rsng_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsng_pkg::status_t status_i,
  output rsng_pkg::cmd_t    cmd_o
);

  rsng_pkg::state_e state_q;
  rsng_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsng_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      rsng_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = rsng_pkg::ST_SQUARE;
        end
      end
      rsng_pkg::ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = rsng_pkg::ST_SUM;
      end
      rsng_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = rsng_pkg::ST_COMPARE;
      end
      rsng_pkg::ST_COMPARE: begin
        cmd_o.compare = 1'b1;
        state_d       = rsng_pkg::ST_GAIN;
      end
      rsng_pkg::ST_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = rsng_pkg::ST_MUL_GAIN;
      end
      rsng_pkg::ST_MUL_GAIN: begin
        cmd_o.mul_gain = 1'b1;
        state_d        = rsng_pkg::ST_MUL_MAKEUP;
      end
      rsng_pkg::ST_MUL_MAKEUP: begin
        cmd_o.mul_makeup = 1'b1;
        state_d          = rsng_pkg::ST_ROUND;
      end
      rsng_pkg::ST_ROUND: begin
        // Hold the finished frame until the output register can take it.
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = rsng_pkg::ST_IDLE;
        end
      end
      default: state_d = rsng_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/rsng_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate datapath
// Sample windows, running sums of squares, threshold compare, gain ramp and
// the output scaling with rounding and saturation.
// ----------------------------------------------------------------------------
module rsng_dp #(
  parameter int WINDOW_DEPTH = rsng_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = rsng_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsng_pkg::cfg_t    cfg_i,
  input  rsng_pkg::cmd_t    cmd_i,
  output rsng_pkg::status_t status_o,
  rsng_in_if.sink           in_i,
  rsng_out_if.source        out_o
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int SQ_W   = 2 * W - 1;
  localparam int SUM_W  = 2 * W - 1 + $clog2(WINDOW_DEPTH);
  localparam int THR2_W = 2 * rsng_pkg::LEVEL_W;
  localparam int LIM_W  = THR2_W + $clog2(WINDOW_DEPTH) + 1;
  localparam int CMP_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;
  localparam int GS_W   = rsng_pkg::GAIN_W + 1;
  localparam int P1_W   = W + GS_W;
  localparam int P2_W   = P1_W + rsng_pkg::MAKEUP_W + 1;
  localparam int SH_W   = P2_W - rsng_pkg::OUT_FRAC;
  localparam int GR_W   = rsng_pkg::GAIN_W + 2;

  // Frame registers
  logic signed [W-1:0] l_q, r_q, nl_q;
  logic signed [W-1:0] old_l, old_r;

  // Squares and running sums
  logic signed [2*W-1:0] sq_nl, sq_ol, sq_nr, sq_or;
  logic [SQ_W-1:0]       sq_nl_q, sq_ol_q, sq_nr_q, sq_or_q;
  logic [THR2_W-1:0]     thr_sq_q;
  logic [SUM_W-1:0]      lsum_q, rsum_q;

  // Detection and gain
  logic [CMP_W-1:0]          level, limit;
  logic                      above_q;
  logic                      up;
  logic [rsng_pkg::STEP_W-1:0] step;
  logic [rsng_pkg::GAIN_W-1:0] gmin;
  logic [GR_W-1:0]           g_up;
  logic signed [GR_W-1:0]    g_dn;
  logic [rsng_pkg::GAIN_W-1:0] gain_d, gain_q;

  // Output scaling
  logic signed [P1_W-1:0] pl_d, pr_d, pl_q, pr_q;
  logic signed [P2_W-1:0] ql_d, qr_d, ql_q, qr_q;
  logic                   out_vld_q;
  logic signed [W-1:0]    out_l_q, out_r_q;
  logic [rsng_pkg::GAIN_W-1:0] out_g_q;

  function automatic logic signed [W-1:0] round_sat(input logic signed [P2_W-1:0] p);
    logic signed [P2_W-1:0] biased;
    logic signed [SH_W-1:0] shifted;
    logic signed [SH_W-1:0] maxv;
    logic signed [SH_W-1:0] minv;
    biased  = p + P2_W'(1 << (rsng_pkg::OUT_FRAC - 1));
    shifted = SH_W'(biased >>> rsng_pkg::OUT_FRAC);
    maxv    = SH_W'((1 << (W - 1)) - 1);
    minv    = -maxv - SH_W'(1);
    if (shifted > maxv) begin
      return maxv[W-1:0];
    end else if (shifted < minv) begin
      return minv[W-1:0];
    end
    return shifted[W-1:0];
  endfunction

  assign in_i.ready        = cmd_i.in_ready;
  assign status_o.in_valid = in_i.valid;
  assign status_o.out_free = !out_vld_q || out_o.ready;

  rsng_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_left_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_i.load),
    .sample_i (cfg_i.sidechain_mode ? in_i.side_sample : in_i.left_sample),
    .old_o    (old_l)
  );

  rsng_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_right_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_i.load && !cfg_i.sidechain_mode),
    .sample_i (in_i.right_sample),
    .old_o    (old_r)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q  <= in_i.left_sample;
      r_q  <= in_i.right_sample;
      nl_q <= cfg_i.sidechain_mode ? in_i.side_sample : in_i.left_sample;
    end
  end

  assign sq_nl = nl_q * nl_q;
  assign sq_ol = old_l * old_l;
  assign sq_nr = r_q * r_q;
  assign sq_or = old_r * old_r;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sq_nl_q  <= sq_nl[SQ_W-1:0];
      sq_ol_q  <= sq_ol[SQ_W-1:0];
      sq_nr_q  <= sq_nr[SQ_W-1:0];
      sq_or_q  <= sq_or[SQ_W-1:0];
      thr_sq_q <= THR2_W'(cfg_i.threshold_level) * THR2_W'(cfg_i.threshold_level);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsum_q <= '0;
      rsum_q <= '0;
    end else if (cmd_i.sum) begin
      lsum_q <= lsum_q - SUM_W'(sq_ol_q) + SUM_W'(sq_nl_q);
      if (!cfg_i.sidechain_mode) begin
        rsum_q <= rsum_q - SUM_W'(sq_or_q) + SUM_W'(sq_nr_q);
      end
    end
  end

  // The RMS test is made on squares: sum > threshold^2 * depth.
  always_comb begin
    if (cfg_i.sidechain_mode || lsum_q > rsum_q) begin
      level = CMP_W'(lsum_q);
    end else begin
      level = CMP_W'(rsum_q);
    end
    limit = CMP_W'(thr_sq_q) * CMP_W'(WINDOW_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
    end else if (cmd_i.compare) begin
      above_q <= level > limit;
    end
  end

  // Inverted mode swaps direction but keeps attack tied to the level being above.
  always_comb begin
    up   = above_q ^ cfg_i.inverted_mode;
    step = above_q ? cfg_i.attack_step : cfg_i.release_step;
    gmin = (cfg_i.min_gate_gain > rsng_pkg::GAIN_ONE) ? rsng_pkg::GAIN_ONE
                                                      : cfg_i.min_gate_gain;
    g_up = {2'b00, gain_q} + {2'b00, step};
    g_dn = $signed({2'b00, gain_q}) - $signed({2'b00, step});
    if (up) begin
      if (g_up > {2'b00, rsng_pkg::GAIN_ONE}) begin
        gain_d = rsng_pkg::GAIN_ONE;
      end else begin
        gain_d = g_up[rsng_pkg::GAIN_W-1:0];
      end
    end else begin
      if (g_dn < $signed({2'b00, gmin})) begin
        gain_d = gmin;
      end else begin
        gain_d = g_dn[rsng_pkg::GAIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
    end else if (cmd_i.gain) begin
      gain_q <= gain_d;
    end
  end

  assign pl_d = l_q * $signed({1'b0, gain_q});
  assign pr_d = r_q * $signed({1'b0, gain_q});
  assign ql_d = pl_q * $signed({1'b0, cfg_i.makeup_gain});
  assign qr_d = pr_q * $signed({1'b0, cfg_i.makeup_gain});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_gain) begin
      pl_q <= pl_d;
      pr_q <= pr_d;
    end
    if (cmd_i.mul_makeup) begin
      ql_q <= ql_d;
      qr_q <= qr_d;
    end
    if (cmd_i.emit) begin
      out_l_q <= round_sat(ql_q);
      out_r_q <= round_sat(qr_q);
      out_g_q <= gain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_left  = out_l_q;
  assign out_o.out_right = out_r_q;
  assign out_o.gate_gain = out_g_q;

endmodule

// ===== design/stereo_rms_noise_gate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo RMS noise gate
// Windowed RMS detector with sidechain option, ramped gate gain and makeup.
// ----------------------------------------------------------------------------
// One frame is processed at a time, and a frame accepted on in_i passes
// through the sequencer's steps: window read, squaring, running-sum update,
// threshold compare, gain ramp, and two multiplier stages before rounding.
// The next frame is accepted in the cycle after the result enters the output
// register. A result still waiting on out_o does not stop the next frame
// from being accepted; only a second finished result waits for the first to
// be taken. The sample windows need no clearing pass after reset. The user
// must see that registers are written on cfg_i while the block is idle; the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module stereo_rms_noise_gate #(
  parameter int WINDOW_DEPTH = rsng_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = rsng_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsng_cfg_if.sink    cfg_i,
  rsng_in_if.sink     in_i,
  rsng_out_if.source  out_o
);

  rsng_pkg::cfg_t    cfg;
  rsng_pkg::cmd_t    cmd;
  rsng_pkg::status_t status;

  rsng_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rsng_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  rsng_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

  // A frame in flight blocks the input until its result is handed over.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a frame is still in flight");

  // A result is only written when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_o.valid || out_o.ready))
    else $error("pending result overwritten");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> (out_o.valid && out_o.gate_gain == $past(u_dp.gain_q)))
    else $error("result not presented after emit");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.gate_gain <= rsng_pkg::GAIN_ONE))
    else $error("gate gain above unity");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo RMS noise gate testbench
// Sends stereo frames with sidechain samples through the gate. Each accepted
// frame is run through a local model of the windowed level detector, the gain
// ramp and the output scaling. Every gated result is checked in order against
// that model, with random gaps on both ends and hold-offs at the receiver.
// ----------------------------------------------------------------------------
module tb;
  import rsng_pkg::*;

  localparam int WINDOW_LEN      = WINDOW_DEPTH_DEF;
  localparam int SW              = SAMPLE_WIDTH_DEF;
  localparam int GAIN_UNITY      = 32768;
  localparam int SAT_MAX         = (1 << (SW - 1)) - 1;
  localparam int SAT_MIN         = -(1 << (SW - 1));
  localparam int CH_LEFT         = 0;
  localparam int CH_RIGHT        = 1;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 250000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct {
    sample_t           out_left;
    sample_t           out_right;
    logic [GAIN_W-1:0] gate_gain;
  } gated_frame_t;

  typedef enum int {
    LVL_FULL,
    LVL_LOUD,
    LVL_QUIET,
    LVL_EDGE
  } level_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rsng_cfg_if                        cfg_bus ();
  rsng_in_if  #(.SAMPLE_WIDTH(SW))   in_bus ();
  rsng_out_if #(.SAMPLE_WIDTH(SW))   out_bus ();

  stereo_rms_noise_gate #(
    .WINDOW_DEPTH(WINDOW_LEN),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local copy of the gate: register file, sample windows, energies and gain.
  cfg_t         gate_cfg;
  sample_t      det_win [2][WINDOW_LEN];
  longint       det_energy [2];
  int           det_slot [2];
  int           ramp_gain;
  gated_frame_t pending_frames [$];

  int error_count;
  int frames_sent;
  int results_checked;
  int cfg_writes;
  int cycle_count;
  bit gaps_on = 1'b1;
  int hold_off_req;
  int hold_off_seen;
  int hold_off_left;
  int rx_pause;

  function automatic longint square_of(sample_t x);
    return longint'(x) * longint'(x);
  endfunction

  // The slot pointer advances first, then the new sample replaces that slot.
  function automatic void push_window(int ch, sample_t x);
    det_slot[ch]   = (det_slot[ch] == WINDOW_LEN - 1) ? 0 : det_slot[ch] + 1;
    det_energy[ch] = det_energy[ch] - square_of(det_win[ch][det_slot[ch]]) + square_of(x);
    det_win[ch][det_slot[ch]] = x;
  endfunction

  // Q1.15 sample times Q1.15 gain times Q5.10 makeup, rounded half up, saturated.
  function automatic sample_t scale_sample(sample_t x, int g);
    longint prod;
    longint rounded;
    prod    = longint'(x) * longint'(g) * longint'(gate_cfg.makeup_gain);
    rounded = (prod + (longint'(1) <<< (OUT_FRAC - 1))) >>> OUT_FRAC;
    if (rounded > SAT_MAX) rounded = SAT_MAX;
    if (rounded < SAT_MIN) rounded = SAT_MIN;
    return rounded[SW-1:0];
  endfunction

  function automatic void predict_gate_frame(sample_t l, sample_t r, sample_t s);
    longint       level;
    longint       limit;
    bit           above;
    bit           rising;
    int           step;
    int           gmin;
    gated_frame_t res;
    if (gate_cfg.sidechain_mode) begin
      push_window(CH_LEFT, s);
      level = det_energy[CH_LEFT];
    end else begin
      push_window(CH_LEFT, l);
      push_window(CH_RIGHT, r);
      level = (det_energy[CH_LEFT] > det_energy[CH_RIGHT]) ? det_energy[CH_LEFT]
                                                           : det_energy[CH_RIGHT];
    end
    // Mean square against threshold squared, scaled up by the window depth.
    limit  = longint'(gate_cfg.threshold_level) * longint'(gate_cfg.threshold_level)
             * WINDOW_LEN;
    above  = level > limit;
    rising = gate_cfg.inverted_mode ? !above : above;
    step   = above ? int'(gate_cfg.attack_step) : int'(gate_cfg.release_step);
    gmin   = (int'(gate_cfg.min_gate_gain) > GAIN_UNITY) ? GAIN_UNITY
                                                        : int'(gate_cfg.min_gate_gain);
    if (rising) begin
      ramp_gain = ramp_gain + step;
      if (ramp_gain > GAIN_UNITY) ramp_gain = GAIN_UNITY;
    end else begin
      ramp_gain = ramp_gain - step;
      if (ramp_gain < gmin) ramp_gain = gmin;
    end
    res.out_left  = scale_sample(l, ramp_gain);
    res.out_right = scale_sample(r, ramp_gain);
    res.gate_gain = ramp_gain[GAIN_W-1:0];
    pending_frames.push_back(res);
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_ATTACK:    gate_cfg.attack_step     = value;
      CFG_RELEASE:   gate_cfg.release_step    = value;
      CFG_THRESHOLD: gate_cfg.threshold_level = value;
      CFG_MAKEUP:    gate_cfg.makeup_gain     = value[MAKEUP_W-1:0];
      CFG_MIN_GAIN:  gate_cfg.min_gate_gain   = value;
      CFG_SIDECHAIN: gate_cfg.sidechain_mode  = value[0];
      CFG_INVERTED:  gate_cfg.inverted_mode   = value[0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic level_kind_e pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return LVL_LOUD;
    if (roll < 70) return LVL_QUIET;
    if (roll < 85) return LVL_EDGE;
    return LVL_FULL;
  endfunction

  function automatic sample_t gen_sample(level_kind_e kind);
    int          mag;
    logic [31:0] raw;
    case (kind)
      LVL_FULL: begin
        raw = $urandom;
        return raw[SW-1:0];
      end
      LVL_LOUD:  mag = $urandom_range(SAT_MAX, 6000);
      LVL_QUIET: mag = $urandom_range(48, 0);
      default: begin
        mag = int'(gate_cfg.threshold_level) + int'($urandom_range(16, 0)) - 8;
        if (mag < 0) mag = 0;
        if (mag > SAT_MAX) mag = SAT_MAX;
      end
    endcase
    if ($urandom_range(1, 0) == 1) mag = -mag;
    return mag[SW-1:0];
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want_v,
                                        logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // Receiver: random gaps, plus a long hold-off whenever a test asks for one.
  always @(negedge clk_i) begin
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen = hold_off_req;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_bus.ready <= 1'b0;
    end else if (rx_pause > 0) begin
      rx_pause--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      rx_pause = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    gated_frame_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_frames.size() == 0) begin
        error_count++;
        $display("%0t ns: result transfer with no frame outstanding, actual %0d %0d %0d",
                 $time, out_bus.out_left, out_bus.out_right, out_bus.gate_gain);
      end else begin
        want = pending_frames.pop_front();
        compare_field("out_left", want.out_left, out_bus.out_left);
        compare_field("out_right", want.out_right, out_bus.out_right);
        compare_field("gate_gain", want.gate_gain, out_bus.gate_gain);
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, pending_frames.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_frame(input sample_t l, input sample_t r, input sample_t s);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.left_sample  <= l;
    in_bus.right_sample <= r;
    in_bus.side_sample  <= s;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predict_gate_frame(l, r, s);
    frames_sent++;
  endtask

  // Drains the block: no frame on offer, all results in, then an idle settling spell.
  task automatic settle_block();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    settle_block();
    @(negedge clk_i);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    store_reg(idx, value);
    cfg_writes++;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] attack, input logic [15:0] release_v,
                                input logic [15:0] thr, input logic [15:0] makeup,
                                input logic [15:0] min_gain, input logic [15:0] side,
                                input logic [15:0] inv);
    write_reg(CFG_ATTACK, attack);
    write_reg(CFG_RELEASE, release_v);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_MAKEUP, makeup);
    write_reg(CFG_MIN_GAIN, min_gain);
    write_reg(CFG_SIDECHAIN, side);
    write_reg(CFG_INVERTED, inv);
  endtask

  // Segments of steady loud, quiet or near-threshold material so the gain ramps
  // all the way in both directions, with some fully random frames mixed in.
  task automatic play_program(input int n_frames);
    int          sent;
    int          seg_len;
    level_kind_e kl;
    level_kind_e kr;
    level_kind_e ks;
    sent = 0;
    while (sent < n_frames) begin
      seg_len = $urandom_range(24, 3);
      kl = pick_kind();
      kr = ($urandom_range(1, 0) == 1) ? kl : pick_kind();
      ks = pick_kind();
      for (int i = 0; i < seg_len && sent < n_frames; i++) begin
        send_frame(gen_sample(kl), gen_sample(kr), gen_sample(ks));
        sent++;
      end
    end
  endtask

  // A level exactly at threshold does not count as above it.
  task automatic test_threshold_edge();
    write_reg(CFG_THRESHOLD, 16'd1);
    send_frame(16'sd8, 16'sd0, 16'sd0);
    send_frame(16'sd0, -16'sd8, 16'sd0);
    send_frame(16'sd1, 16'sd0, 16'sd0);
  endtask

  task automatic test_rounding_and_saturation();
    // Gain jumps straight to one, makeup of one half puts products on exact halves.
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_ATTACK, 16'd32768);
    write_reg(CFG_MAKEUP, 16'd512);
    send_frame(16'sd1, -16'sd1, 16'sd0);
    send_frame(16'sd3, -16'sd3, 16'sd0);
    send_frame(-16'sd32768, 16'sd32767, 16'sd0);
    // The top bit of the write data is dropped, leaving the largest makeup.
    write_reg(CFG_MAKEUP, 16'hFFFF);
    send_frame(16'sd32767, -16'sd32768, 16'sd0);
    send_frame(-16'sd32768, 16'sd32767, -16'sd1);
    send_frame(16'sd5, -16'sd5, 16'sd0);
    // A minimum gain above one holds the gain at one against a full release.
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_RELEASE, 16'hFFFF);
    write_reg(CFG_MIN_GAIN, 16'hFFFF);
    send_frame(16'sd32767, 16'sd32767, 16'sd32767);
    write_reg(CFG_MIN_GAIN, 16'd0);
    send_frame(16'sd32767, -16'sd32768, 16'sd0);
  endtask

  task automatic test_modes_directed();
    apply_settings(16'd4096, 16'd4096, 16'd100, 16'd1024, 16'd0, 16'd1, 16'd0);
    send_frame(16'sd0, 16'sd0, 16'sd32767);
    send_frame(16'sd32767, -16'sd32768, 16'sd0);
    send_frame(16'sd0, 16'sd0, -16'sd32768);
    // Only bit zero of a mode register counts.
    write_reg(CFG_SIDECHAIN, 16'hFFFE);
    write_reg(CFG_INVERTED, 16'd1);
    send_frame(16'sd32767, 16'sd32767, 16'sd0);
    send_frame(16'sd0, 16'sd0, 16'sd0);
    send_frame(16'sd0, 16'sd0, 16'sd0);
    // A write to an index past the register map changes nothing.
    write_reg(CFG_SPARE, 16'hFFFF);
    send_frame(-16'sd32768, -16'sd32768, -16'sd32768);
  endtask

  task automatic test_gate_normal_random();
    apply_settings(16'd2048, 16'd1024, 16'd1200, 16'd1024, 16'd4096, 16'd0, 16'd0);
    play_program(110);
  endtask

  task automatic test_gate_inverted_random();
    apply_settings(16'd512, 16'd3000, 16'd2500, 16'd2048, 16'd0, 16'd0, 16'd1);
    play_program(80);
  endtask

  task automatic test_sidechain_random();
    apply_settings(16'd6000, 16'd800, 16'd900, 16'd1536, 16'd8192, 16'd1, 16'd0);
    play_program(80);
  endtask

  // Run back to back with no idling on either side.
  task automatic test_sidechain_inverted_random();
    apply_settings(16'd32768, 16'd32768, 16'd300, 16'd32767, 16'd32768, 16'd1, 16'd1);
    gaps_on = 1'b0;
    play_program(40);
    settle_block();
    gaps_on = 1'b1;
  endtask

  // Zero steps freeze the gain and zero makeup silences the outputs.
  task automatic test_frozen_ramp();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    play_program(30);
  endtask

  task automatic test_register_ceiling();
    apply_settings(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 16'd0);
    play_program(40);
  endtask

  // The receiver stops for a long stretch while frames keep coming, so the
  // block fills up and refuses further input until the stall ends.
  task automatic test_output_backpressure();
    apply_settings(16'd3000, 16'd3000, 16'd1500, 16'd1024, 16'd0, 16'd0, 16'd0);
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_off_req++;
    play_program(40);
    settle_block();
    gaps_on = 1'b1;
  endtask

  initial begin
    cfg_bus.valid       = 1'b0;
    cfg_bus.reg_index   = CFG_ATTACK;
    cfg_bus.wdata       = '0;
    in_bus.valid        = 1'b0;
    in_bus.left_sample  = '0;
    in_bus.right_sample = '0;
    in_bus.side_sample  = '0;
    out_bus.ready       = 1'b0;

    gate_cfg.attack_step     = ATTACK_RST;
    gate_cfg.release_step    = RELEASE_RST;
    gate_cfg.threshold_level = THRESHOLD_RST;
    gate_cfg.makeup_gain     = MAKEUP_RST;
    gate_cfg.min_gate_gain   = MIN_GAIN_RST;
    gate_cfg.sidechain_mode  = 1'b0;
    gate_cfg.inverted_mode   = 1'b0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      det_win[CH_LEFT][i]  = '0;
      det_win[CH_RIGHT][i] = '0;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_threshold_edge();
    test_rounding_and_saturation();
    test_modes_directed();
    test_gate_normal_random();
    test_gate_inverted_random();
    test_sidechain_random();
    test_sidechain_inverted_random();
    test_frozen_ramp();
    test_register_ceiling();
    test_output_backpressure();

    settle_block();
    $display("Run covered %0d frames and %0d gated results over %0d register writes.",
             frames_sent, results_checked, cfg_writes);
    $display("Included threshold edge, rounding, saturation, both modes and output stall.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
